>>> hdl/sewv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sewv_pkg
// Types and constants shared by the serial EEPROM write/verify sequencer.
// ----------------------------------------------------------------------------
package sewv_pkg;

    localparam logic [2:0] OP_STATUS = 3'b001;
    localparam logic [2:0] OP_READ   = 3'b010;
    localparam logic [2:0] OP_WRITE  = 3'b100;

    localparam logic       OPC_START = 1'b0;
    localparam logic       OPC_TICK  = 1'b1;

    localparam logic [0:0] CFG_BUSY_LIMIT  = 1'b0;
    localparam logic [0:0] CFG_RETRY_LIMIT = 1'b1;

    localparam logic [15:0] BUSY_LIMIT_RST  = 16'd100;
    localparam logic [15:0] RETRY_LIMIT_RST = 16'd3;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_RDSR  = 3'd1,
        CMD_READ  = 3'd2,
        CMD_WREN  = 3'd3,
        CMD_WRITE = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        PH_CHOOSE = 3'd0,
        PH_STATUS = 3'd1,
        PH_READ   = 3'd2,
        PH_WREN   = 3'd3,
        PH_WRITE  = 3'd4
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  pending_ops;
        logic [15:0] cur_address;
        logic [15:0] bytes_left;
        logic [15:0] busy_polls;
        logic [15:0] retries_used;
        logic [7:0]  pending_byte;
        logic [15:0] assembled_word;
        logic [15:0] word_offset;
        logic        error_flag;
        logic        buffer_present;
    } seq_state_t;

    typedef struct packed {
        logic        opcode;
        logic [2:0]  request_flags;
        logic [15:0] start_address;
        logic [15:0] byte_count;
        logic        has_buffer;
        logic [15:0] write_word;
        logic [7:0]  spi_reply;
    } req_item_t;

    typedef struct packed {
        cmd_t        spi_command;
        logic [15:0] spi_address;
        logic [7:0]  spi_data;
        logic [15:0] read_data;
        logic        read_word_valid;
        logic [15:0] word_index;
        logic        active;
        logic        error;
    } res_item_t;

    typedef struct packed {
        logic [15:0] busy_limit;
        logic [15:0] retry_limit;
    } seq_cfg_t;

endpackage : sewv_pkg
`default_nettype wire

>>> hdl/spi_eeprom_write_verify_sequencer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spi_eeprom_write_verify_sequencer_top
// Serial EEPROM command sequencer with write, read-back verify and retry.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Carries
// s_*       in   tvalid/tready      start request or tick with device reply
// m_*       out  tvalid/tready      one command/result per request
// cfg_*     in   cfg_we             busy_limit (0), retry_limit (1)
//
// Every accepted request yields exactly one result. A request is held in the
// input register; the step logic then updates the sequencer state and
// loads the result register in the same cycle, so throughput is one request
// per clock while m_tready does not stall. A request passes the input
// register and then the result register before m_tvalid rises. A stalled
// m_tready holds the result; the input register still takes one more
// request. rst_n clears control state and loads the limits to 100 and 3.
// ----------------------------------------------------------------------------
module spi_eeprom_write_verify_sequencer_top #(
    parameter int ADDR_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [0] opcode
    input  wire logic [0:0]  s_tuser,
    // [2:0] request_flags, [18:3] start_address, [34:19] byte_count,
    // [35] has_buffer, [51:36] write_word, [59:52] spi_reply, [63:60] zero
    input  wire logic [63:0] s_tdata,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] read_word_valid
    output logic [0:0]       m_tuser,
    // [2:0] spi_command, [18:3] spi_address, [26:19] spi_data,
    // [42:27] read_data, [58:43] word_index, [59] active, [60] error,
    // [63:61] zero
    output logic [63:0]      m_tdata,

    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import sewv_pkg::*;

    logic       in_valid_reg;
    req_item_t  in_item_reg;
    logic       out_valid_reg;
    res_item_t  out_item_reg;
    seq_state_t st_reg;
    seq_state_t st_next;
    res_item_t  res_next;
    seq_cfg_t   cfg_reg;
    req_item_t  s_item;
    logic       advance;

    // unpack the incoming request
    assign s_item.opcode        = s_tuser[0];
    assign s_item.request_flags = s_tdata[2:0];
    assign s_item.start_address = s_tdata[18:3];
    assign s_item.byte_count    = s_tdata[34:19];
    assign s_item.has_buffer    = s_tdata[35];
    assign s_item.write_word    = s_tdata[51:36];
    assign s_item.spi_reply     = s_tdata[59:52];

    // step fires when a request is held and the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_item_reg <= s_item;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.busy_limit  <= BUSY_LIMIT_RST;
            cfg_reg.retry_limit <= RETRY_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BUSY_LIMIT:  cfg_reg.busy_limit  <= cfg_data;
                CFG_RETRY_LIMIT: cfg_reg.retry_limit <= cfg_data;
                default:         cfg_reg.busy_limit  <= cfg_reg.busy_limit;
            endcase
        end
    end

    sewv_step #(
        .ADDR_BITS (ADDR_BITS)
    ) u_step (
        .st      (st_reg),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // sequencer state, all cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase          <= PH_CHOOSE;
            st_reg.pending_ops    <= 3'b000;
            st_reg.cur_address    <= 16'h0000;
            st_reg.bytes_left     <= 16'h0000;
            st_reg.busy_polls     <= 16'h0000;
            st_reg.retries_used   <= 16'h0000;
            st_reg.pending_byte   <= 8'h00;
            st_reg.assembled_word <= 16'h0000;
            st_reg.word_offset    <= 16'h0000;
            st_reg.error_flag     <= 1'b0;
            st_reg.buffer_present <= 1'b0;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_item_reg.read_word_valid;
    assign m_tdata  = {3'b000,
                       out_item_reg.error,
                       out_item_reg.active,
                       out_item_reg.word_index,
                       out_item_reg.read_data,
                       out_item_reg.spi_data,
                       out_item_reg.spi_address,
                       out_item_reg.spi_command};

endmodule : spi_eeprom_write_verify_sequencer_top
`default_nettype wire

>>> hdl/sewv_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sewv_step
// One sequencer step: next state and result for one request.
// ----------------------------------------------------------------------------
module sewv_step #(
    parameter int ADDR_BITS = 16
) (
    input  sewv_pkg::seq_state_t st,
    input  sewv_pkg::req_item_t  item,
    input  sewv_pkg::seq_cfg_t   cfg,
    output sewv_pkg::seq_state_t st_next,
    output sewv_pkg::res_item_t  res
);
    import sewv_pkg::*;

    localparam logic [15:0] ADDR_MASK = (ADDR_BITS >= 16) ? 16'hFFFF
                                      : 16'((32'd1 << ADDR_BITS) - 32'd1);

    logic [16:0] busy_inc;
    logic [16:0] retry_inc;
    logic [15:0] wr_src;
    logic        advance;

    assign busy_inc  = {1'b0, st.busy_polls} + 17'd1;
    assign retry_inc = {1'b0, st.retries_used} + 17'd1;
    assign wr_src    = st.buffer_present ? item.write_word : 16'h0000;

    always_comb
    begin
        st_next             = st;
        advance             = 1'b0;
        res.spi_command     = CMD_NONE;
        res.spi_address     = 16'h0000;
        res.spi_data        = 8'h00;
        res.read_word_valid = 1'b0;
        res.word_index      = st.word_offset;

        if (item.opcode == OPC_START)
        begin
            st_next.pending_ops    = item.request_flags;
            st_next.cur_address    = item.start_address & ADDR_MASK;
            st_next.bytes_left     = item.byte_count;
            st_next.buffer_present = item.has_buffer;
            st_next.error_flag     = 1'b0;
            st_next.phase          = PH_CHOOSE;
            st_next.busy_polls     = 16'h0000;
            st_next.retries_used   = 16'h0000;
            st_next.word_offset    = 16'h0000;
            res.word_index         = 16'h0000;
        end
        else if (st.pending_ops == 3'b000)
        begin
            st_next.phase = PH_CHOOSE;
        end
        else
        begin
            case (st.phase)
                PH_CHOOSE:
                begin
                    if ((st.pending_ops & OP_STATUS) != 3'b000)
                        st_next.phase = PH_STATUS;
                    else if ((st.pending_ops & OP_READ) != 3'b000)
                        st_next.phase = PH_READ;
                    else
                        st_next.phase = PH_WREN;
                end
                PH_STATUS:
                begin
                    res.spi_command = CMD_RDSR;
                    st_next.phase   = PH_CHOOSE;
                    if ((st.pending_ops & OP_WRITE) == 3'b000)
                    begin
                        st_next.assembled_word = {8'h00, item.spi_reply};
                        res.read_word_valid    = 1'b1;
                        st_next.pending_ops    = 3'b000;
                    end
                    else if (!item.spi_reply[0])
                    begin
                        st_next.pending_ops = st.pending_ops & ~OP_STATUS;
                    end
                    else
                    begin
                        // device still busy: poll again until the limit
                        st_next.busy_polls = busy_inc[16] ? 16'hFFFF : busy_inc[15:0];
                        if (busy_inc < {1'b0, cfg.busy_limit})
                            st_next.phase = PH_STATUS;
                        else
                        begin
                            st_next.error_flag  = 1'b1;
                            st_next.pending_ops = 3'b000;
                        end
                    end
                end
                PH_READ:
                begin
                    res.spi_command = CMD_READ;
                    res.spi_address = st.cur_address;
                    st_next.phase   = PH_CHOOSE;
                    if ((st.pending_ops & OP_WRITE) == 3'b000)
                    begin
                        advance = 1'b1;
                        if (!st.cur_address[0])
                            st_next.assembled_word = {8'h00, item.spi_reply};
                        else
                        begin
                            st_next.assembled_word = {item.spi_reply,
                                                      st.assembled_word[7:0]};
                            res.read_word_valid    = 1'b1;
                        end
                    end
                    else if (item.spi_reply != st.pending_byte)
                    begin
                        // verify mismatch: rewrite the same byte until the retry limit
                        st_next.retries_used = retry_inc[16] ? 16'hFFFF
                                                             : retry_inc[15:0];
                        if (retry_inc < {1'b0, cfg.retry_limit})
                            st_next.pending_ops = st.pending_ops & ~OP_READ;
                        else
                        begin
                            st_next.error_flag  = 1'b1;
                            st_next.pending_ops = 3'b000;
                        end
                    end
                    else
                    begin
                        advance              = 1'b1;
                        st_next.retries_used = 16'h0000;
                        st_next.pending_ops  = st.pending_ops & ~OP_READ;
                    end

                    if (advance)
                    begin
                        if (st.bytes_left > 16'd1)
                        begin
                            if (st.buffer_present && st.cur_address[0])
                                st_next.word_offset = st.word_offset + 16'd1;
                            st_next.cur_address = (st.cur_address + 16'd1) & ADDR_MASK;
                            st_next.bytes_left  = st.bytes_left - 16'd1;
                        end
                        else
                        begin
                            st_next.retries_used = 16'h0000;
                            st_next.bytes_left   = 16'h0000;
                            st_next.pending_ops  = 3'b000;
                        end
                    end
                end
                PH_WREN:
                begin
                    st_next.pending_byte = st.cur_address[0] ? wr_src[15:8] : wr_src[7:0];
                    res.spi_command      = CMD_WREN;
                    st_next.phase        = PH_WRITE;
                end
                PH_WRITE:
                begin
                    res.spi_command     = CMD_WRITE;
                    res.spi_address     = st.cur_address;
                    res.spi_data        = st.pending_byte;
                    st_next.pending_ops = st.pending_ops | OP_STATUS | OP_READ;
                    st_next.busy_polls  = 16'h0000;
                    st_next.phase       = PH_CHOOSE;
                end
                default:
                begin
                    st_next.phase = PH_CHOOSE;
                end
            endcase
        end

        res.read_data = st_next.assembled_word;
        res.active    = (st_next.pending_ops != 3'b000);
        res.error     = st_next.error_flag;
    end

endmodule : sewv_step
`default_nettype wire

>>> dv/spi_eeprom_write_verify_sequencer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_eeprom_write_verify_sequencer_top_tb
// Self-checking bench for the EEPROM sequencer. Requests enter on the s_*
// stream. A behavioural copy of the sequencer predicts the command and result
// fields for every accepted request. The m_* stream is compared against the
// predictions in order. Device replies come from a small device model that
// tracks the predicted state, so the write, poll and verify loops get deep
// coverage. Limits are reprogrammed between phases, and both sides of the
// stream idle at random.
// ----------------------------------------------------------------------------
module spi_eeprom_write_verify_sequencer_top_tb;
    import sewv_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [0:0]  s_tuser;     // [0] opcode
    logic [63:0] s_tdata;     // [2:0] flags, [18:3] addr, [34:19] count, [35] buffer,
                              // [51:36] write word, [59:52] reply, [63:60] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [0:0]  m_tuser;     // [0] read_word_valid
    logic [63:0] m_tdata;     // [2:0] cmd, [18:3] addr, [26:19] data, [42:27] read data,
                              // [58:43] word index, [59] active, [60] error
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;

    spi_eeprom_write_verify_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Shadow of the sequencer state and its limits
    phase_t      m_phase;
    logic [2:0]  m_pending;
    logic [15:0] m_addr, m_left, m_busy, m_retries, m_word, m_offset;
    logic [7:0]  m_pbyte;
    logic        m_err, m_buf;
    logic [15:0] m_busy_lim = BUSY_LIMIT_RST;
    logic [15:0] m_retry_lim = RETRY_LIMIT_RST;

    res_item_t   predicted_cmds[$];
    int          err_cnt = 0;
    int          requests_sent = 0;

    // Stimulus knobs
    int          busy_pct = 30;      // chance a status poll sees the device busy
    int          mismatch_pct = 20;  // chance the read-back differs
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int          rx_hold = 0;

    // One step of the sequencer: updates the shadow state, returns the result
    task automatic sequence_step(input req_item_t rq, output res_item_t rs);
        int unsigned n;
        logic [15:0] idx;
        logic [15:0] wv;
        logic        advance;
        rs = '0;
        idx = m_offset;
        advance = 1'b0;
        if (rq.opcode == OPC_START) begin
            m_pending = rq.request_flags;
            m_addr    = rq.start_address;
            m_left    = rq.byte_count;
            m_buf     = rq.has_buffer;
            m_err     = 1'b0;
            m_phase   = PH_CHOOSE;
            m_busy    = '0;
            m_retries = '0;
            m_offset  = '0;
            idx       = '0;
        end else if (m_pending == 3'b000) begin
            m_phase = PH_CHOOSE;
        end else begin
            case (m_phase)
                PH_CHOOSE: begin
                    if ((m_pending & OP_STATUS) != 0)     m_phase = PH_STATUS;
                    else if ((m_pending & OP_READ) != 0)  m_phase = PH_READ;
                    else                                  m_phase = PH_WREN;
                end
                PH_STATUS: begin
                    rs.spi_command = CMD_RDSR;
                    m_phase = PH_CHOOSE;
                    if ((m_pending & OP_WRITE) == 0) begin
                        m_word = {8'h00, rq.spi_reply};
                        rs.read_word_valid = 1'b1;
                        m_pending = 3'b000;
                    end else if (!rq.spi_reply[0]) begin
                        m_pending &= ~OP_STATUS;
                    end else begin
                        n = m_busy + 1;
                        m_busy = (n > 32'hFFFF) ? 16'hFFFF : 16'(n);
                        if (n < m_busy_lim) begin
                            m_phase = PH_STATUS;
                        end else begin
                            m_err = 1'b1;
                            m_pending = 3'b000;
                        end
                    end
                end
                PH_READ: begin
                    rs.spi_command = CMD_READ;
                    rs.spi_address = m_addr;
                    m_phase = PH_CHOOSE;
                    if ((m_pending & OP_WRITE) == 0) begin
                        if (!m_addr[0]) begin
                            m_word = {8'h00, rq.spi_reply};
                        end else begin
                            m_word = {rq.spi_reply, m_word[7:0]};
                            rs.read_word_valid = 1'b1;
                        end
                        advance = 1'b1;
                    end else if (rq.spi_reply != m_pbyte) begin
                        // verify failed: go round the write again or give up
                        n = m_retries + 1;
                        m_retries = (n > 32'hFFFF) ? 16'hFFFF : 16'(n);
                        if (n < m_retry_lim) begin
                            m_pending &= ~OP_READ;
                        end else begin
                            m_err = 1'b1;
                            m_pending = 3'b000;
                        end
                    end else begin
                        m_retries = '0;
                        m_pending &= ~OP_READ;
                        advance = 1'b1;
                    end
                    if (advance) begin
                        if (m_left > 16'd1) begin
                            if (m_buf && m_addr[0])
                                m_offset = m_offset + 16'd1;
                            m_addr = m_addr + 16'd1;
                            m_left = m_left - 16'd1;
                        end else begin
                            m_retries = '0;
                            m_left = '0;
                            m_pending = 3'b000;
                        end
                    end
                end
                PH_WREN: begin
                    wv = m_buf ? rq.write_word : 16'h0000;
                    m_pbyte = m_addr[0] ? wv[15:8] : wv[7:0];
                    rs.spi_command = CMD_WREN;
                    m_phase = PH_WRITE;
                end
                PH_WRITE: begin
                    rs.spi_command = CMD_WRITE;
                    rs.spi_address = m_addr;
                    rs.spi_data = m_pbyte;
                    m_pending |= OP_STATUS | OP_READ;
                    m_busy = '0;
                    m_phase = PH_CHOOSE;
                end
                default: m_phase = PH_CHOOSE;
            endcase
        end
        rs.read_data  = m_word;
        rs.word_index = idx;
        rs.active     = (m_pending != 3'b000);
        rs.error      = m_err;
    endtask

    function automatic int idle_len();
        int r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic req_item_t start_request(input logic [2:0] flags,
                                                input logic [15:0] addr,
                                                input logic [15:0] count,
                                                input logic buf_on);
        req_item_t rq;
        rq.opcode        = OPC_START;
        rq.request_flags = flags;
        rq.start_address = addr;
        rq.byte_count    = count;
        rq.has_buffer    = buf_on;
        rq.write_word    = 16'($urandom);
        rq.spi_reply     = 8'($urandom);
        return rq;
    endfunction

    // Ticks carry random junk in the start-only fields
    function automatic req_item_t tick_request(input logic [7:0] reply);
        req_item_t rq;
        rq.opcode        = OPC_TICK;
        rq.request_flags = 3'($urandom);
        rq.start_address = 16'($urandom);
        rq.byte_count    = 16'($urandom);
        rq.has_buffer    = 1'($urandom);
        rq.write_word    = 16'($urandom);
        rq.spi_reply     = reply;
        return rq;
    endfunction

    // Device model: busy bit and read-back driven by the predicted phase
    function automatic logic [7:0] device_reply();
        logic [7:0] r = 8'($urandom);
        if ((m_pending & OP_WRITE) != 0) begin
            if (m_phase == PH_STATUS)
                r[0] = ($urandom_range(0, 99) < busy_pct);
            else if (m_phase == PH_READ && $urandom_range(0, 99) >= mismatch_pct)
                r = m_pbyte;
        end
        return r;
    endfunction

    task automatic send_request(input req_item_t rq);
        int gap = tx_idle_on ? idle_len() : 0;
        res_item_t rs;
        if (gap > 0) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= rq.opcode;
        s_tdata  <= {4'b0000, rq.spi_reply, rq.write_word, rq.has_buffer,
                     rq.byte_count, rq.start_address, rq.request_flags};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sequence_step(rq, rs);
        predicted_cmds.push_back(rs);
        requests_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (predicted_cmds.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Only ever called with the block idle
    task automatic program_limits(input logic [15:0] busy_lim, input logic [15:0] retry_lim);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BUSY_LIMIT;
        cfg_data  <= busy_lim;
        @(negedge clk);
        cfg_index <= CFG_RETRY_LIMIT;
        cfg_data  <= retry_lim;
        @(negedge clk);
        cfg_we    <= 1'b0;
        m_busy_lim  = busy_lim;
        m_retry_lim = retry_lim;
    endtask

    // Start followed by ticks until the sequencer goes idle or the cap is hit;
    // a capped run is abandoned by whatever start comes next
    task automatic run_transfer(input logic [2:0] flags, input logic [15:0] addr,
                                input logic [15:0] count, input logic buf_on,
                                input int cap);
        int ticks = 0;
        send_request(start_request(flags, addr, count, buf_on));
        while (m_pending != 3'b000 && ticks < cap) begin
            send_request(tick_request(device_reply()));
            ticks++;
        end
    endtask

    task automatic random_transfer();
        logic [15:0] addr;
        logic [15:0] count;
        case ($urandom_range(0, 3))
            0:       addr = 16'hFFFF - 16'($urandom_range(0, 3));
            1:       addr = 16'($urandom_range(0, 7));
            default: addr = 16'($urandom);
        endcase
        count = ($urandom_range(0, 31) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
        run_transfer(3'($urandom_range(1, 7)), addr, count, $urandom_range(0, 4) != 0,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10) : 60);
    endtask

    // Broken sequences: random starts, stray ticks, garbage replies
    task automatic random_noise();
        int k = $urandom_range(0, 3);
        if ($urandom_range(0, 1))
            send_request(start_request(3'($urandom), 16'($urandom), 16'($urandom),
                                       1'($urandom)));
        else
            send_request(tick_request(8'($urandom)));
        repeat (k) send_request(tick_request(8'($urandom)));
    endtask

    task automatic random_traffic(input int budget);
        int stop_at = requests_sent + budget;
        while (requests_sent < stop_at) begin
            if ($urandom_range(0, 99) < 85) random_transfer();
            else random_noise();
            if ($urandom_range(0, 49) == 0) wait_drained();
        end
    endtask

    // ---- tests ----

    task automatic test_idle_ticks();
        send_request(tick_request(8'h00));
        send_request(tick_request(8'hFF));
        run_transfer(3'b000, 16'h1234, 16'h0001, 1'b1, 2);
    endtask

    task automatic test_basic_ops();
        busy_pct = 50;
        mismatch_pct = 0;
        run_transfer(OP_STATUS, 16'h0000, 16'h0000, 1'b1, 4);
        // odd start, then the address wraps
        run_transfer(OP_READ, 16'hFFFF, 16'h0002, 1'b1, 8);
        // zero count, no buffer
        run_transfer(OP_WRITE, 16'h0001, 16'h0000, 1'b0, 20);
        // maximal request abandoned by the next start
        run_transfer(3'b111, 16'hFFFE, 16'hFFFF, 1'b1, 3);
        run_transfer(OP_READ | OP_WRITE, 16'h0000, 16'h0001, 1'b1, 20);
    endtask

    task automatic test_limit_errors();
        program_limits(16'd0, 16'd1);
        busy_pct = 100;
        mismatch_pct = 0;
        run_transfer(OP_WRITE, 16'h0010, 16'h0001, 1'b1, 20);
        busy_pct = 0;
        mismatch_pct = 100;
        run_transfer(OP_WRITE, 16'h0011, 16'h0001, 1'b1, 20);
    endtask

    task automatic test_default_limits();
        program_limits(BUSY_LIMIT_RST, RETRY_LIMIT_RST);
        busy_pct = 30;
        mismatch_pct = 20;
        random_traffic(283);
    endtask

    task automatic test_tight_limits();
        program_limits(16'd1, 16'd1);
        busy_pct = 10;
        mismatch_pct = 10;
        random_traffic(283);
    endtask

    task automatic test_wide_limits();
        program_limits(16'hFFFF, 16'hFFFF);
        busy_pct = 50;
        mismatch_pct = 40;
        random_traffic(283);
    endtask

    // Full-rate streaming on both sides
    task automatic test_back_to_back();
        program_limits(16'($urandom_range(2, 8)), 16'($urandom_range(2, 8)));
        busy_pct = 30;
        mismatch_pct = 25;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        random_traffic(283);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_zero_limits();
        program_limits(16'd0, 16'd0);
        busy_pct = 20;
        mismatch_pct = 20;
        random_traffic(283);
    endtask

    // ---- sink side: random back-pressure ----
    always @(negedge clk) begin
        if (!rx_idle_on) begin
            m_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            rx_hold = idle_len();
            m_tready <= (rx_hold == 0);
            if (rx_hold > 0) rx_hold = rx_hold - 1;
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge clk) begin : result_check
        res_item_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (predicted_cmds.size() == 0) begin
                $error("result with no request outstanding");
                err_cnt++;
            end else begin
                want = predicted_cmds.pop_front();
                check_field("spi_command", want.spi_command, m_tdata[2:0]);
                check_field("spi_address", want.spi_address, m_tdata[18:3]);
                check_field("spi_data", want.spi_data, m_tdata[26:19]);
                check_field("read_data", want.read_data, m_tdata[42:27]);
                check_field("read_word_valid", want.read_word_valid, m_tuser[0]);
                check_field("word_index", want.word_index, m_tdata[58:43]);
                check_field("active", want.active, m_tdata[59]);
                check_field("error", want.error, m_tdata[60]);
                check_field("m_tdata pad", 0, m_tdata[63:61]);
            end
        end
    end

    initial begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = '0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_BUSY_LIMIT;
        cfg_data  = '0;
        m_phase   = PH_CHOOSE;
        m_pending = '0;
        {m_addr, m_left, m_busy, m_retries, m_word, m_offset} = '0;
        m_pbyte   = '0;
        m_err     = 1'b0;
        m_buf     = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_ticks();
        test_basic_ops();
        test_limit_errors();
        test_default_limits();
        test_tight_limits();
        test_wide_limits();
        test_back_to_back();
        test_zero_limits();

        wait_drained();
        repeat (10) @(posedge clk);
        if (err_cnt == 0 && predicted_cmds.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
hdl/sewv_pkg.sv
hdl/sewv_step.sv
hdl/spi_eeprom_write_verify_sequencer_top.sv
dv/spi_eeprom_write_verify_sequencer_top_tb.sv
